### hw/rtl/hkd_pkg.sv
// ----------------------------------------------------------------------------
// hkd_pkg
// Shared types, constants and helpers of the histogram key frame detector.
// ----------------------------------------------------------------------------
package hkd_pkg;

	// default sizing
	localparam int unsigned MaxFramePixels = 4194304;
	localparam int unsigned NumBins        = 10;

	// fixed field widths
	localparam int unsigned PixelW   = 8;
	localparam int unsigned IndexW   = 4;
	localparam int unsigned CountW   = 23;
	localparam int unsigned ThreshW  = 10;
	localparam int unsigned ApbDataW = 32;
	localparam int unsigned ApbAddrW = 2;

	// intensity span of one bin
	localparam int unsigned BinWidth = 30;
	localparam int unsigned MaxRawBin = 255 / BinWidth;

	// register map and reset values
	localparam logic [ApbAddrW-1:0] AddrThreshold = ApbAddrW'(0);
	localparam logic [ThreshW-1:0]  ThreshReset   = ThreshW'(205);

	// pixel beat
	typedef struct packed {
		logic [PixelW-1:0] pixel;
		logic              end_of_frame;
	} pix_beat_t;

	// result beat: one bin of a key frame
	typedef struct packed {
		logic [IndexW-1:0] bin_index;
		logic [CountW-1:0] bin_count;
		logic              last_bin;
	} bin_beat_t;

	// outcome of one frame comparison
	typedef struct packed {
		logic valid;
		logic key;
	} verdict_t;

	// bin of a pixel: pixel / 30 by threshold compares, clamped to the last bin
	function automatic logic [IndexW-1:0] bin_of(input logic [PixelW-1:0] pix,
			input logic [IndexW-1:0] last);
		logic [IndexW-1:0] b;
		b = '0;
		for (int k = 1; k <= MaxRawBin; k++) begin
			if (pix >= PixelW'(k * BinWidth))
				b = b + IndexW'(1);
		end
		if (b > last)
			b = last;
		return b;
	endfunction

endpackage

### hw/rtl/hkd_ifs.sv
// ----------------------------------------------------------------------------
// hkd stream interfaces
// Valid/ready channels for pixel beats and result beats.
// ----------------------------------------------------------------------------

// pixel channel
interface hkd_pix_if;
	logic              valid;
	logic              ready;
	hkd_pkg::pix_beat_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// result channel
interface hkd_bin_if;
	logic              valid;
	logic              ready;
	hkd_pkg::bin_beat_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/histogram_keyframe_detector.sv
// A frame-end pixel passes the input, snapshot, similarity and verdict registers
// before the first bin beat of a key frame; bins follow one per cycle while
// key_bins is ready. Throughput: one pixel per cycle; a frame-end pixel waits in
// the input register while the last comparison and its burst of bins run.
// Reset: asynchronous, active low; clears histograms and valids; threshold 205.
// ----------------------------------------------------------------------------
// histogram_keyframe_detector
// Histogram intersection shot boundary detector with APB threshold register.
// ----------------------------------------------------------------------------
module histogram_keyframe_detector #(
	parameter int unsigned MAX_FRAME_PIXELS = hkd_pkg::MaxFramePixels,
	parameter int unsigned NUM_BINS         = hkd_pkg::NumBins
) (
	input  logic                         clk,
	input  logic                         arst_n,
	hkd_pix_if.sink                      pixels,
	hkd_bin_if.source                    key_bins,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [hkd_pkg::ApbAddrW-1:0] paddr,
	input  logic [hkd_pkg::ApbDataW-1:0] pwdata,
	output logic [hkd_pkg::ApbDataW-1:0] prdata,
	output logic                         pready
);

	localparam int unsigned CW = $clog2(MAX_FRAME_PIXELS + 1);

	logic [hkd_pkg::ThreshW-1:0] threshold;
	logic [CW-1:0]               cmp_prev [NUM_BINS];
	logic [CW-1:0]               cmp_cur  [NUM_BINS];
	logic                        start;
	logic                        sim_busy;
	logic                        emit_busy;
	hkd_pkg::verdict_t           verdict;

	// configuration
	hkd_apb_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.threshold (threshold)
	);

	// pixel counting
	hkd_bin_counter #(
		.MAX_FRAME_PIXELS (MAX_FRAME_PIXELS),
		.NUM_BINS         (NUM_BINS),
		.CW               (CW)
	) u_counter (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pixels.valid),
		.in_ready (pixels.ready),
		.in_data  (pixels.data),
		.hold     (sim_busy || emit_busy),
		.cmp_prev (cmp_prev),
		.cmp_cur  (cmp_cur),
		.start    (start)
	);

	// frame comparison
	hkd_similarity #(
		.NUM_BINS (NUM_BINS),
		.CW       (CW)
	) u_similarity (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cmp_prev  (cmp_prev),
		.cmp_cur   (cmp_cur),
		.threshold (threshold),
		.verdict   (verdict),
		.busy      (sim_busy)
	);

	// key frame burst
	hkd_emitter #(
		.NUM_BINS (NUM_BINS),
		.CW       (CW)
	) u_emitter (
		.clk       (clk),
		.arst_n    (arst_n),
		.verdict   (verdict),
		.cmp_prev  (cmp_prev),
		.out_valid (key_bins.valid),
		.out_ready (key_bins.ready),
		.out_data  (key_bins.data),
		.busy      (emit_busy)
	);

endmodule

### hw/rtl/hkd_apb_regs.sv
// ----------------------------------------------------------------------------
// hkd_apb_regs
// APB register file holding the similarity threshold.
// ----------------------------------------------------------------------------
module hkd_apb_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [hkd_pkg::ApbAddrW-1:0] paddr,
	input  logic [hkd_pkg::ApbDataW-1:0] pwdata,
	output logic [hkd_pkg::ApbDataW-1:0] prdata,
	output logic                         pready,
	output logic [hkd_pkg::ThreshW-1:0]  threshold
);

	logic [hkd_pkg::ThreshW-1:0] thresh_q;
	logic                        wr_en;

	// write strobe on the access phase
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready && (paddr == hkd_pkg::AddrThreshold);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= hkd_pkg::ThreshReset;
		end else if (wr_en) begin
			thresh_q <= pwdata[hkd_pkg::ThreshW-1:0];
		end
	end

	// read back
	always_comb begin
		prdata = '0;
		if (paddr == hkd_pkg::AddrThreshold)
			prdata = hkd_pkg::ApbDataW'(thresh_q);
	end

	assign threshold = thresh_q;

endmodule

### hw/rtl/hkd_bin_counter.sv
// ----------------------------------------------------------------------------
// hkd_bin_counter
// Input register and saturating bin counters; snapshots both histograms at
// each frame end for the comparison.
// ----------------------------------------------------------------------------
module hkd_bin_counter #(
	parameter int unsigned MAX_FRAME_PIXELS = hkd_pkg::MaxFramePixels,
	parameter int unsigned NUM_BINS         = hkd_pkg::NumBins,
	parameter int unsigned CW               = $clog2(MAX_FRAME_PIXELS + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  hkd_pkg::pix_beat_t in_data,
	input  logic               hold,
	output logic [CW-1:0]      cmp_prev [NUM_BINS],
	output logic [CW-1:0]      cmp_cur  [NUM_BINS],
	output logic               start
);

	logic                        s1_valid;
	hkd_pkg::pix_beat_t          beat_s1;
	logic                        advance;
	logic [hkd_pkg::IndexW-1:0]  bin;
	logic [CW-1:0]               cur_q  [NUM_BINS];
	logic [CW-1:0]               prev_q [NUM_BINS];
	logic [CW-1:0]               nxt    [NUM_BINS];
	logic [CW-1:0]               cmp_prev_q [NUM_BINS];
	logic [CW-1:0]               cmp_cur_q  [NUM_BINS];
	logic                        have_prev_q;
	logic                        start_q;

	// a frame end waits while the previous comparison or burst is in flight
	assign advance  = s1_valid && (!beat_s1.end_of_frame || !(hold || start_q));
	assign in_ready = !s1_valid || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (in_valid && in_ready) begin
			s1_valid <= 1'b1;
		end else if (advance) begin
			s1_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			beat_s1 <= in_data;
	end

	// saturating increment of the addressed bin
	assign bin = hkd_pkg::bin_of(beat_s1.pixel, hkd_pkg::IndexW'(NUM_BINS - 1));

	always_comb begin
		for (int i = 0; i < NUM_BINS; i++) begin
			nxt[i] = cur_q[i];
			if (bin == hkd_pkg::IndexW'(i) && cur_q[i] < CW'(MAX_FRAME_PIXELS))
				nxt[i] = cur_q[i] + CW'(1);
		end
	end

	// histogram state; at frame end current moves to previous
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BINS; i++) begin
				cur_q[i]  <= '0;
				prev_q[i] <= '0;
			end
			have_prev_q <= 1'b0;
			start_q     <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (advance) begin
				if (beat_s1.end_of_frame) begin
					for (int i = 0; i < NUM_BINS; i++) begin
						cur_q[i]  <= '0;
						prev_q[i] <= nxt[i];
					end
					have_prev_q <= 1'b1;
					start_q     <= have_prev_q;
				end else begin
					for (int i = 0; i < NUM_BINS; i++)
						cur_q[i] <= nxt[i];
				end
			end
		end
	end

	// snapshot of the pair under comparison
	always_ff @(posedge clk) begin
		if (advance && beat_s1.end_of_frame) begin
			for (int i = 0; i < NUM_BINS; i++) begin
				cmp_prev_q[i] <= prev_q[i];
				cmp_cur_q[i]  <= nxt[i];
			end
		end
	end

	assign cmp_prev = cmp_prev_q;
	assign cmp_cur  = cmp_cur_q;
	assign start    = start_q;

endmodule

### hw/rtl/hkd_similarity.sv
// ----------------------------------------------------------------------------
// hkd_similarity
// Pipelined histogram intersection test: per-bin minima and totals, two
// levels of summation, threshold product, compare.
// ----------------------------------------------------------------------------
module hkd_similarity #(
	parameter int unsigned NUM_BINS = hkd_pkg::NumBins,
	parameter int unsigned CW       = $clog2(hkd_pkg::MaxFramePixels + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [CW-1:0]               cmp_prev [NUM_BINS],
	input  logic [CW-1:0]               cmp_cur  [NUM_BINS],
	input  logic [hkd_pkg::ThreshW-1:0] threshold,
	output hkd_pkg::verdict_t           verdict,
	output logic                        busy
);

	localparam int unsigned MSW  = CW + 4;
	localparam int unsigned TW   = CW + 5;
	localparam int unsigned PW   = TW + hkd_pkg::ThreshW;
	localparam int unsigned HALF = (NUM_BINS + 1) / 2;

	logic              v_s1, v_s2, v_s3, v_s4;
	logic [CW-1:0]     min_s1 [NUM_BINS];
	logic [CW:0]       tot_s1 [NUM_BINS];
	logic [MSW-1:0]    min_lo_s2, min_hi_s2;
	logic [TW-1:0]     tot_lo_s2, tot_hi_s2;
	logic [MSW-1:0]    min_lo, min_hi;
	logic [TW-1:0]     tot_lo, tot_hi;
	logic [MSW-1:0]    min_sum_s3;
	logic [TW-1:0]     total_s3;
	logic [PW-1:0]     lhs_s4, rhs_s4;
	hkd_pkg::verdict_t verdict_q;

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			verdict_q <= '0;
		end else begin
			v_s1            <= start;
			v_s2            <= v_s1;
			v_s3            <= v_s2;
			v_s4            <= v_s3;
			verdict_q.valid <= v_s4;
			verdict_q.key   <= v_s4 && (lhs_s4 < rhs_s4);
		end
	end

	// per-bin minimum and pair total
	always_ff @(posedge clk) begin
		for (int i = 0; i < NUM_BINS; i++) begin
			min_s1[i] <= (cmp_prev[i] < cmp_cur[i]) ? cmp_prev[i] : cmp_cur[i];
			tot_s1[i] <= {1'b0, cmp_prev[i]} + {1'b0, cmp_cur[i]};
		end
	end

	// half sums
	always_comb begin
		min_lo = '0;
		min_hi = '0;
		tot_lo = '0;
		tot_hi = '0;
		for (int i = 0; i < NUM_BINS; i++) begin
			if (i < HALF) begin
				min_lo = min_lo + MSW'(min_s1[i]);
				tot_lo = tot_lo + TW'(tot_s1[i]);
			end else begin
				min_hi = min_hi + MSW'(min_s1[i]);
				tot_hi = tot_hi + TW'(tot_s1[i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		min_lo_s2 <= min_lo;
		min_hi_s2 <= min_hi;
		tot_lo_s2 <= tot_lo;
		tot_hi_s2 <= tot_hi;
	end

	// full sums
	always_ff @(posedge clk) begin
		min_sum_s3 <= min_lo_s2 + min_hi_s2;
		total_s3   <= tot_lo_s2 + tot_hi_s2;
	end

	// 2 * 256 * min sum against threshold * total
	always_ff @(posedge clk) begin
		lhs_s4 <= PW'({min_sum_s3, 9'b0});
		rhs_s4 <= PW'(threshold) * PW'(total_s3);
	end

	assign verdict = verdict_q;
	assign busy    = v_s1 || v_s2 || v_s3 || v_s4 || verdict_q.valid;

endmodule

### hw/rtl/hkd_emitter.sv
// ----------------------------------------------------------------------------
// hkd_emitter
// Sends the bins of a key frame one beat at a time through the result
// register.
// ----------------------------------------------------------------------------
module hkd_emitter #(
	parameter int unsigned NUM_BINS = hkd_pkg::NumBins,
	parameter int unsigned CW       = $clog2(hkd_pkg::MaxFramePixels + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  hkd_pkg::verdict_t  verdict,
	input  logic [CW-1:0]      cmp_prev [NUM_BINS],
	output logic               out_valid,
	input  logic               out_ready,
	output hkd_pkg::bin_beat_t out_data,
	output logic               busy
);

	localparam int unsigned IW  = $clog2(NUM_BINS);
	localparam int unsigned EXT = (CW > hkd_pkg::CountW) ? CW : hkd_pkg::CountW;

	logic               active_q;
	logic [IW-1:0]      idx_q;
	logic               load;
	logic               last;
	logic [EXT-1:0]     count_ext;
	logic               out_valid_q;
	hkd_pkg::bin_beat_t out_q;

	assign load      = active_q && (!out_valid_q || out_ready);
	assign last      = (idx_q == IW'(NUM_BINS - 1));
	assign count_ext = EXT'(cmp_prev[idx_q]);

	// burst sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (verdict.valid && verdict.key) begin
				active_q <= 1'b1;
				idx_q    <= '0;
			end else if (load) begin
				idx_q <= idx_q + IW'(1);
				if (last)
					active_q <= 1'b0;
			end
			if (load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (load) begin
			out_q.bin_index <= hkd_pkg::IndexW'(idx_q);
			out_q.bin_count <= count_ext[hkd_pkg::CountW-1:0];
			out_q.last_bin  <= last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign busy      = active_q;

endmodule
